// ===== sv/sicxe_pkg.sv =====
package sicxe_pkg;

  // Opcodes that need their own handling
  localparam logic [7:0] OP_LDB    = 8'h68;
  localparam logic [7:0] OP_RSUB   = 8'h4C;

  // Format 1 opcodes
  localparam logic [7:0] OP_FIX    = 8'hC4;
  localparam logic [7:0] OP_FLOAT  = 8'hC0;
  localparam logic [7:0] OP_HIO    = 8'hF4;
  localparam logic [7:0] OP_NORM   = 8'hC8;
  localparam logic [7:0] OP_SIO    = 8'hF0;
  localparam logic [7:0] OP_TIO    = 8'hF8;

  // Format 2 opcodes
  localparam logic [7:0] OP_ADDR   = 8'h90;
  localparam logic [7:0] OP_SUBR   = 8'h94;
  localparam logic [7:0] OP_MULR   = 8'h98;
  localparam logic [7:0] OP_COMPR  = 8'hA0;
  localparam logic [7:0] OP_SHIFTL = 8'hA4;
  localparam logic [7:0] OP_SHIFTR = 8'hA8;
  localparam logic [7:0] OP_RMO    = 8'hAC;
  localparam logic [7:0] OP_SVC    = 8'hB0;
  localparam logic [7:0] OP_CLEAR  = 8'hB4;
  localparam logic [7:0] OP_TIXR   = 8'hB8;

  // Format codes, equal to instruction length in bytes
  localparam logic [2:0] FMT_1 = 3'd1;
  localparam logic [2:0] FMT_2 = 3'd2;
  localparam logic [2:0] FMT_3 = 3'd3;
  localparam logic [2:0] FMT_4 = 3'd4;

  // Field widths
  localparam int DISP3_WIDTH = 12;   // format 3 displacement, range 4096
  localparam int FIELD_WIDTH = 20;   // address-sized output fields
  localparam logic [2:0] PC_STEP = 3'd3;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [19:0] location;
    logic [2:0]  format;
    logic [7:0]  opcode;
    logic [5:0]  mode_bits;
    logic [19:0] displacement;
    logic [19:0] target_address;
    logic        target_valid;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic        two_registers;
    logic        no_operand;
    logic        sets_base;
  } out_item_t;

endpackage

// ===== sv/sicxe_decode.sv =====
module sicxe_decode #(
  parameter int ADDR_WIDTH = 20
) (
  input  sicxe_pkg::in_item_t  item,
  input  logic [19:0]          start_address,
  input  logic [ADDR_WIDTH-1:0] loc_cur,
  input  logic [ADDR_WIDTH-1:0] base_cur,
  output sicxe_pkg::out_item_t result,
  output logic [ADDR_WIDTH-1:0] loc_nxt,
  output logic [ADDR_WIDTH-1:0] base_nxt
);

  logic [ADDR_WIDTH-1:0] loc;
  logic [ADDR_WIDTH-1:0] base;
  logic [ADDR_WIDTH-1:0] target;
  logic [ADDR_WIDTH-1:0] sdisp;
  logic [2:0]            fmt;
  logic [7:0]            b0;
  logic [7:0]            b1;
  logic                  n_bit;
  logic                  i_bit;
  logic                  b_bit;
  logic                  p_bit;
  logic [19:0]           disp;

  assign b0    = item.first_byte;
  assign b1    = item.second_byte;
  assign n_bit = b0[1];
  assign i_bit = b0[0];
  assign b_bit = b1[6];
  assign p_bit = b1[5];

  // Restart reloads the counter and clears base before this instruction
  assign loc  = item.restart ? ADDR_WIDTH'(start_address) : loc_cur;
  assign base = item.restart ? '0 : base_cur;

  // Format from the opcode byte, e bit picks 4 over 3
  always_comb begin
    case (b0) inside
      sicxe_pkg::OP_FIX, sicxe_pkg::OP_FLOAT, sicxe_pkg::OP_HIO,
      sicxe_pkg::OP_NORM, sicxe_pkg::OP_SIO, sicxe_pkg::OP_TIO: begin
        fmt = sicxe_pkg::FMT_1;
      end
      sicxe_pkg::OP_ADDR, sicxe_pkg::OP_SUBR, sicxe_pkg::OP_MULR,
      sicxe_pkg::OP_COMPR, sicxe_pkg::OP_SHIFTL, sicxe_pkg::OP_SHIFTR,
      sicxe_pkg::OP_RMO, sicxe_pkg::OP_SVC, sicxe_pkg::OP_CLEAR,
      sicxe_pkg::OP_TIXR: begin
        fmt = sicxe_pkg::FMT_2;
      end
      default: begin
        fmt = b1[4] ? sicxe_pkg::FMT_4 : sicxe_pkg::FMT_3;
      end
    endcase
  end

  // Displacement: 12 bits in format 3, full 20-bit address in format 4
  assign disp = (fmt == sicxe_pkg::FMT_4) ? {b1[3:0], item.third_byte, item.fourth_byte}
                                          : {8'd0, b1[3:0], item.third_byte};

  // PC-relative offset, sign extended from 12 bits
  assign sdisp = {{(ADDR_WIDTH - sicxe_pkg::DISP3_WIDTH){disp[sicxe_pkg::DISP3_WIDTH-1]}},
                  disp[sicxe_pkg::DISP3_WIDTH-1:0]};

  // Target address: format 4 and SIC form are direct; base-relative wins over PC-relative
  always_comb begin
    if (fmt == sicxe_pkg::FMT_4) begin
      target = ADDR_WIDTH'(disp);
    end else if (!(n_bit || i_bit)) begin
      target = ADDR_WIDTH'(disp);
    end else if (b_bit) begin
      target = base + ADDR_WIDTH'(disp);
    end else if (p_bit) begin
      target = loc + ADDR_WIDTH'(sicxe_pkg::PC_STEP) + sdisp;
    end else begin
      target = ADDR_WIDTH'(disp);
    end
  end

  // Result fields
  always_comb begin
    result                = '0;
    result.location       = sicxe_pkg::FIELD_WIDTH'(loc);
    result.format         = fmt;
    result.opcode         = b0;
    base_nxt              = base;
    case (fmt)
      sicxe_pkg::FMT_1: begin
        result.no_operand = 1'b1;
      end
      sicxe_pkg::FMT_2: begin
        result.reg_first = b1[7:4];
        if (b0 != sicxe_pkg::OP_CLEAR && b0 != sicxe_pkg::OP_TIXR) begin
          result.reg_second    = b1[3:0];
          result.two_registers = 1'b1;
        end
      end
      sicxe_pkg::FMT_3, sicxe_pkg::FMT_4: begin
        result.opcode         = {b0[7:2], 2'b00};
        result.mode_bits      = {b0[1:0], b1[7:4]};
        result.displacement   = disp;
        result.target_address = sicxe_pkg::FIELD_WIDTH'(target);
        result.target_valid   = 1'b1;
        if ({b0[7:2], 2'b00} == sicxe_pkg::OP_LDB) begin
          result.sets_base = 1'b1;
          base_nxt         = target;
        end
        if ({b0[7:2], 2'b00} == sicxe_pkg::OP_RSUB) begin
          result.no_operand = 1'b1;
        end
      end
      default: begin
        result.no_operand = 1'b0;
      end
    endcase
  end

  // Location counter advances by the instruction length
  assign loc_nxt = loc + ADDR_WIDTH'(fmt);

endmodule

// ===== sv/sic_xe_instruction_decoder_top.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  sicxe_pkg::in_item_t   (four code bytes, restart)
// out_     output     out_valid/out_stall sicxe_pkg::out_item_t (decoded instruction)
// cfg_     input      cfg_we             cfg_wdata: start_address, 20 bits
//
// One transaction per cycle sustained while out_stall is low; out_valid rises once the
// accepted input has passed the input register, decode and result register.
// The location counter and base register update as a transaction moves from the
// input register into the result register, so the next one sees them at once.
// Synchronous active-low reset clears both, start_address and the valid flags.
// out_stall holds the result register; the input register keeps accepting until
// both stages are full, then in_stall rises.
module sic_xe_instruction_decoder_top #(
  parameter int ADDR_WIDTH = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sicxe_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sicxe_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [19:0]          cfg_wdata
);

  logic                  in_vld_r;
  sicxe_pkg::in_item_t   in_item_r;
  logic                  out_vld_r;
  sicxe_pkg::out_item_t  out_item_r;
  logic [19:0]           start_r;
  logic [ADDR_WIDTH-1:0] loc_r;
  logic [ADDR_WIDTH-1:0] base_r;
  logic [ADDR_WIDTH-1:0] loc_nxt;
  logic [ADDR_WIDTH-1:0] base_nxt;
  sicxe_pkg::out_item_t  result;
  logic                  advance;
  logic                  in_take;

  // Pipeline flow control
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  sicxe_decode #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_decode (
    .item         (in_item_r),
    .start_address(start_r),
    .loc_cur      (loc_r),
    .base_cur     (base_r),
    .result       (result),
    .loc_nxt      (loc_nxt),
    .base_nxt     (base_nxt)
  );

  // Control state and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      start_r   <= '0;
      loc_r     <= '0;
      base_r    <= '0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        loc_r     <= loc_nxt;
        base_r    <= base_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
